FILE: src/bclc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclc_pkg
// Shared types and constants of the bitmap/character layer compositor.
// ----------------------------------------------------------------------------
package bclc_pkg;

    // Item kind codes
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_BM_WRITE   = 2'd0;
    localparam kind_t KIND_CHAR_WRITE = 2'd1;
    localparam kind_t KIND_RENDER     = 2'd2;

    // Configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ALT_LAYOUT     = 1'd0;
    localparam cfg_idx_t CFG_CONTROL_INVERT = 1'd1;

    // Field widths
    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 8;
    localparam int COLOR_W = 3;
    localparam int COORD_W = 8;
    localparam int PEN_W   = 10;

    typedef logic [PEN_W-1:0] pen_t;

    // Storage sizes
    localparam int GROUP_COUNT_DEF = 8192;
    localparam int CHAR_DEPTH      = 8192;
    localparam int GROUP_BYTES     = 8;

    // Palette pens outside the character range
    localparam pen_t PEN_BM_BASE = 10'h200;
    localparam pen_t PEN_BG      = 10'h208;

endpackage

FILE: src/bclc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclc_ram
// Generic single-port RAM: one write or read address per cycle, registered
// read data, no reset on contents.
// ----------------------------------------------------------------------------
module bclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bitmap_char_layer_compositor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_char_layer_compositor_core
// Bitmap plus character layer compositor: RAM fill and 8-pixel group render.
// ----------------------------------------------------------------------------
// A RAM write beat is written on accept and leaves the item channel open. A
// render beat issues the bitmap, colour and code reads on accept, then makes
// three reads on the single character RAM port (code, plane one, plane two),
// then shifts eight pixels out one per cycle while the output is not stalled,
// most significant bit first, from the bitmap and plane shift registers. Only
// one item is in flight; in_stall stays high until the eighth pixel sits in
// the output register. No clearing pass: unwritten RAM entries read as junk.
// ----------------------------------------------------------------------------
module bitmap_char_layer_compositor_core #(
    parameter int GROUP_COUNT = bclc_pkg::GROUP_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Item channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bclc_pkg::kind_t               kind,
    input  logic [bclc_pkg::ADDR_W-1:0]   address,
    input  logic [bclc_pkg::DATA_W-1:0]   data,
    input  logic [bclc_pkg::COLOR_W-1:0]  color_latch,
    input  logic                          flip_control,
    // Pixel channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bclc_pkg::COORD_W-1:0]  pixel_x,
    output logic [bclc_pkg::COORD_W-1:0]  pixel_y,
    output bclc_pkg::pen_t                pen_index,
    output logic                          last,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  bclc_pkg::cfg_idx_t            cfg_index,
    input  logic                          cfg_data
);

    import bclc_pkg::*;

    localparam int GA_W  = $clog2(GROUP_COUNT);
    localparam int COL_D = GROUP_COUNT / GROUP_BYTES;
    localparam int CA_W  = $clog2(CHAR_DEPTH);

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CODE  = 3'd1;
    localparam logic [2:0] S_P1    = 3'd2;
    localparam logic [2:0] S_P2    = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                alt_reg, ctrl_inv_reg;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                flip_reg, flip_next;
    logic [DATA_W-1:0]   code_reg, code_next;
    logic [COLOR_W-1:0]  colour_reg, colour_next;
    logic [DATA_W-1:0]   bm_sh_reg, bm_sh_next;
    logic [DATA_W-1:0]   p1_sh_reg, p1_sh_next;
    logic [DATA_W-1:0]   p2_sh_reg, p2_sh_next;
    logic [2:0]          pix_reg, pix_next;

    logic                out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]  px_reg, px_next;
    logic [COORD_W-1:0]  py_reg, py_next;
    pen_t                pen_reg, pen_next;
    logic                last_reg, last_next;

    logic                in_accept;
    logic                out_free;
    logic                emit;
    logic [DATA_W-1:0]   bm_rdata;
    logic [COLOR_W-1:0]  col_rdata;
    logic [DATA_W-1:0]   char_rdata;
    logic [CA_W-1:0]     char_addr;
    logic [9:0]          plane_base;
    logic                bbit;
    logic [1:0]          pix_a;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == S_SHIFT) && out_free;

    // Memories
    bclc_ram #(.WIDTH(DATA_W), .DEPTH(GROUP_COUNT)) u_bm_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_BM_WRITE),
        .addr  (address[GA_W-1:0]),
        .wdata (data),
        .rdata (bm_rdata)
    );

    bclc_ram #(.WIDTH(COLOR_W), .DEPTH(COL_D)) u_col_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_BM_WRITE),
        .addr  (address[GA_W-1:$clog2(GROUP_BYTES)]),
        .wdata (color_latch),
        .rdata (col_rdata)
    );

    bclc_ram #(.WIDTH(DATA_W), .DEPTH(CHAR_DEPTH)) u_char_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_CHAR_WRITE),
        .addr  (char_addr),
        .wdata (data),
        .rdata (char_rdata)
    );

    // Character RAM address: write/code fetch, then plane one, then plane two
    always_comb
    begin
        plane_base = 10'(code_reg[6:0]) << 3 | 10'(addr_reg[2:0]);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && kind == KIND_RENDER)
                    char_addr = {alt_reg, 2'b00, address[12:3]};
                else
                    char_addr = address;
            end
            S_CODE:  char_addr = {2'b00, char_rdata[7],
                                  char_rdata[6:0], addr_reg[2:0]};
            S_P1:    char_addr = {2'b01, code_reg[7], plane_base};
            default: char_addr = address;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_reg      <= 1'b0;
            ctrl_inv_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index == CFG_ALT_LAYOUT)
                alt_reg <= cfg_data;
            else if (cfg_index == CFG_CONTROL_INVERT)
                ctrl_inv_reg <= cfg_data;
        end
    end

    // Per-pixel pen from the current shift register heads
    always_comb
    begin
        bbit  = bm_sh_reg[DATA_W-1];
        pix_a = {p2_sh_reg[DATA_W-1], p1_sh_reg[DATA_W-1]};
        if (pix_a == 2'b00 || (bbit && code_reg[7:6] == 2'b11))
            pen_next = bbit ? (PEN_BM_BASE | pen_t'(colour_reg)) : PEN_BG;
        else
            pen_next = {1'b0, code_reg[7:1], pix_a};
    end

    // Sequencer and shift datapath
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        flip_next      = flip_reg;
        code_next      = code_reg;
        colour_next    = colour_reg;
        bm_sh_next     = bm_sh_reg;
        p1_sh_next     = p1_sh_reg;
        p2_sh_next     = p2_sh_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && out_stall;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && kind == KIND_RENDER)
                begin
                    addr_next  = address;
                    flip_next  = alt_reg ? flip_control
                                         : !(flip_control ^ ctrl_inv_reg);
                    state_next = S_CODE;
                end
            end
            S_CODE:
            begin
                code_next   = char_rdata;
                bm_sh_next  = bm_rdata;
                colour_next = col_rdata;
                state_next  = S_P1;
            end
            S_P1:
            begin
                // set 0 has no plane one in the standard layout
                p1_sh_next = (code_reg[7] || alt_reg) ? char_rdata : '0;
                state_next = S_P2;
            end
            S_P2:
            begin
                p2_sh_next = char_rdata;
                pix_next   = 3'd0;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    px_next    = {~addr_reg[12:8], pix_reg} ^ {COORD_W{flip_reg}};
                    py_next    = addr_reg[7:0] ^ {COORD_W{flip_reg}};
                    last_next  = (pix_reg == 3'd7);
                    bm_sh_next = bm_sh_reg << 1;
                    p1_sh_next = p1_sh_reg << 1;
                    p2_sh_next = p2_sh_reg << 1;
                    pix_next   = pix_reg + 3'd1;
                    if (pix_reg == 3'd7)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pix_reg       <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pix_reg       <= pix_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        flip_reg   <= flip_next;
        code_reg   <= code_next;
        colour_reg <= colour_next;
        bm_sh_reg  <= bm_sh_next;
        p1_sh_reg  <= p1_sh_next;
        p2_sh_reg  <= p2_sh_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
        if (emit)
            pen_reg <= pen_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign pen_index = pen_reg;
    assign last      = last_reg;

endmodule

FILE: src/bclc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclc_checker
// Port-level checks of the compositor, bound to the top level.
// ----------------------------------------------------------------------------
module bclc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  bclc_pkg::kind_t               kind,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [bclc_pkg::COORD_W-1:0]  pixel_x,
    input  logic [bclc_pkg::COORD_W-1:0]  pixel_y,
    input  bclc_pkg::pen_t                pen_index,
    input  logic                          last
);

    import bclc_pkg::*;

    // Stalled pixel beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x)
            && $stable(pixel_y) && $stable(pen_index) && $stable(last))
    else $error("stalled pixel beat changed");

    // A render keeps the item channel closed after its accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_RENDER |=> in_stall)
    else $error("render accept did not close the item channel");

    // A RAM write completes in its own cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_BM_WRITE || kind == KIND_CHAR_WRITE)
        |=> !in_stall)
    else $error("write beat kept the block busy");

    // A mid-group pixel on the output means the group is still being shifted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
    else $error("item channel open while a group is unfinished");

endmodule

bind bitmap_char_layer_compositor_core bclc_checker u_bclc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pen_index    (pen_index),
    .last         (last)
);

FILE: tb/bitmap_char_layer_compositor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_char_layer_compositor_core_tb
// Self-checking bench for the bitmap/character compositor. RAM fill and
// render beats are queued phase by phase under several layout settings;
// every render is preceded by the writes it needs so no unwritten entry is
// ever used for a pixel. A shadow of the three RAMs computes the eight expected
// pixels of each accepted render, and each pixel beat is checked field by field.
// ----------------------------------------------------------------------------
module bitmap_char_layer_compositor_core_tb;
    import bclc_pkg::*;

    localparam kind_t KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES = 5;
    localparam int OPS_PER_PHASE = 70;

    typedef struct packed {
        kind_t       kind;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [2:0]  latch;
        logic        flip;
    } video_op_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        pen_t       pen;
        logic       last;
    } pixel_t;

    // DUT ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    kind_t               kind = KIND_BM_WRITE;
    logic [ADDR_W-1:0]   address = '0;
    logic [DATA_W-1:0]   data = '0;
    logic [COLOR_W-1:0]  color_latch = '0;
    logic                flip_control = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    pen_t                pen_index;
    logic                last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_idx_t            cfg_index = CFG_ALT_LAYOUT;
    logic                cfg_data = 1'b0;

    // Ops waiting to be sent, pixels waiting to come out
    video_op_t ops_pending[$];
    pixel_t    pixels_due[$];

    // Shadow RAMs and layout registers, updated on accepted beats
    logic [7:0] bmap_mem   [0:8191];
    logic [2:0] colour_mem [0:1023];
    logic [7:0] char_mem   [0:8191];
    logic       cur_alt = 1'b0;
    logic       cur_inv = 1'b0;

    // Generator view: which entries a queued write has covered
    bit         bm_written   [0:8191];
    bit         char_written [0:8191];
    logic [7:0] gen_char     [0:8191];
    logic       gen_alt = 1'b0;
    logic [12:0] hot_offs [0:7];
    int         issued_cnt = 0;

    int   mismatch_cnt = 0;
    int   pixel_cnt = 0;
    int   idle_cycles = 0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   send_gap = 0;
    bit   send_burst = 0;
    int   stall_left = 0;
    bit   stall_burst = 0;

    bitmap_char_layer_compositor_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .color_latch  (color_latch),
        .flip_control (flip_control),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pen_index    (pen_index),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_cnt++;
    endtask

    // Expected eight pixels of one group, MSB first
    task automatic compose_group(input logic [12:0] offs, input logic flip);
        logic [7:0]  bm, code, p1, p2, x0;
        logic [2:0]  colour;
        logic [12:0] code_addr, base;
        logic [1:0]  a;
        logic        bbit, flipped;
        pixel_t      px;
        int          i;
        bm = bmap_mem[offs];
        colour = colour_mem[offs[12:3]];
        code_addr = {cur_alt, 2'b00, offs[12:3]};
        code = char_mem[code_addr];
        base = {3'b000, code[6:0], offs[2:0]};
        if (code[7])
        begin
            p1 = char_mem[base | 13'h0400];
            p2 = char_mem[base | 13'h0c00];
        end
        else
        begin
            p1 = cur_alt ? char_mem[base] : 8'h00;
            p2 = char_mem[base | 13'h0800];
        end
        flipped = cur_alt ? flip : ~(flip ^ cur_inv);
        x0 = {~offs[12:8], 3'b000};
        for (i = 0; i < 8; i++)
        begin
            bbit = bm[7-i];
            a = {p2[7-i], p1[7-i]};
            // bitmap shows through on empty char pixels, or over top-priority codes
            if (a == 2'b00 || (bbit && code[7:6] == 2'b11))
                px.pen = bbit ? PEN_BM_BASE + colour : PEN_BG;
            else
                px.pen = {1'b0, code[7:1], a};
            px.x = x0 + 8'(i);
            px.y = offs[7:0];
            if (flipped)
            begin
                px.x = ~px.x;
                px.y = ~px.y;
            end
            px.last = (i == 7);
            pixels_due.push_back(px);
        end
    endtask

    task automatic apply_op;
        case (kind)
            KIND_BM_WRITE:
            begin
                bmap_mem[address] = data;
                colour_mem[address[12:3]] = color_latch;
            end
            KIND_CHAR_WRITE: char_mem[address] = data;
            KIND_RENDER:     compose_group(address, flip_control);
            default: ;
        endcase
    endtask

    task automatic check_pixel;
        pixel_t want;
        if (pixels_due.size() == 0)
        begin
            flag_mismatch($sformatf("pixel with none due: x=%0d y=%0d pen=%0d last=%0b",
                                    pixel_x, pixel_y, pen_index, last));
            return;
        end
        want = pixels_due.pop_front();
        if (pixel_x !== want.x)
            flag_mismatch($sformatf("pixel %0d x got %0d want %0d", pixel_cnt, pixel_x, want.x));
        if (pixel_y !== want.y)
            flag_mismatch($sformatf("pixel %0d y got %0d want %0d", pixel_cnt, pixel_y, want.y));
        if (pen_index !== want.pen)
            flag_mismatch($sformatf("pixel %0d pen got %0d want %0d",
                                    pixel_cnt, pen_index, want.pen));
        if (last !== want.last)
            flag_mismatch($sformatf("pixel %0d last got %0b want %0b",
                                    pixel_cnt, last, want.last));
        pixel_cnt++;
    endtask

    // Sample handshakes, predict, check, watchdog
    always @(posedge clk)
    begin
        bit busy;
        busy = 0;
        in_fire <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                busy = 1;
                if (cfg_index == CFG_ALT_LAYOUT)
                    cur_alt = cfg_data;
                else
                    cur_inv = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1;
                check_pixel();
            end
            if (in_valid && !in_stall)
            begin
                busy = 1;
                apply_op();
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** bitmap_char_layer_compositor_core: FAILED **");
                $finish;
            end
        end
    end

    // Item driver: random gap before each beat, bursts with no gap
    always @(negedge clk)
    begin
        video_op_t op;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (ops_pending.size() > 0)
            begin
                op = ops_pending.pop_front();
                in_valid <= 1'b1;
                kind <= op.kind;
                address <= op.addr;
                data <= op.data;
                color_latch <= op.latch;
                flip_control <= op.flip;
                send_gap = send_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Pixel sink: random stall after each beat, bursts with no stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                stall_left = stall_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 59) == 0)
                    stall_burst = !stall_burst;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_op(input kind_t k, input logic [12:0] a, input logic [7:0] d,
                           input logic [2:0] c, input logic f);
        video_op_t op;
        op.kind = k;
        op.addr = a;
        op.data = d;
        op.latch = c;
        op.flip = f;
        ops_pending.push_back(op);
        if (k == KIND_BM_WRITE)
            bm_written[a] = 1;
        if (k == KIND_CHAR_WRITE)
        begin
            char_written[a] = 1;
            gen_char[a] = d;
        end
        if (k != KIND_UNUSED)
            issued_cnt++;
    endtask

    task automatic push_char(input logic [12:0] a);
        push_op(KIND_CHAR_WRITE, a, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)));
    endtask

    // Render beat, preceded by writes to every entry it needs that is still blank
    task automatic queue_render(input logic [12:0] offs, input logic f);
        logic [12:0] code_addr, base, p1_addr, p2_addr;
        logic [7:0]  code;
        logic        need_p1;
        if (!bm_written[offs])
            push_op(KIND_BM_WRITE, offs, 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        code_addr = {gen_alt, 2'b00, offs[12:3]};
        if (!char_written[code_addr])
            push_char(code_addr);
        code = gen_char[code_addr];
        base = {3'b000, code[6:0], offs[2:0]};
        if (code[7])
        begin
            need_p1 = 1'b1;
            p1_addr = base | 13'h0400;
            p2_addr = base | 13'h0c00;
        end
        else
        begin
            need_p1 = gen_alt;
            p1_addr = base;
            p2_addr = base | 13'h0800;
        end
        if (need_p1 && !char_written[p1_addr])
            push_char(p1_addr);
        if (!char_written[p2_addr])
            push_char(p2_addr);
        push_op(KIND_RENDER, offs, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), f);
    endtask

    function automatic logic [12:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return hot_offs[$urandom_range(0, 7)];
        if (r < 58)
            return 13'h0000;
        if (r < 61)
            return 13'h1fff;
        return 13'($urandom_range(0, 8191));
    endfunction

    task automatic random_ops(input int n);
        int          goal, r;
        logic [12:0] a;
        goal = issued_cnt + n;
        while (issued_cnt < goal)
        begin
            r = $urandom_range(0, 99);
            a = pick_offset();
            if (r < 55)
                queue_render(a, 1'($urandom_range(0, 1)));
            else if (r < 70)
                push_op(KIND_BM_WRITE, a, 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            else if (r < 92)
            begin
                // retarget a code, rewrite a plane byte, or hit anywhere
                case ($urandom_range(0, 2))
                    0: push_char({gen_alt, 2'b00, a[12:3]});
                    1: push_char(13'($urandom_range(0, 4095)));
                    default: push_char(13'($urandom_range(0, 8191)));
                endcase
            end
            else
                push_op(KIND_UNUSED, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic directed_ops;
        // top-priority code over a busy bitmap, both flip states
        push_op(KIND_CHAR_WRITE, 13'h0000, 8'hc1, 3'h0, 1'b0);
        push_op(KIND_BM_WRITE, 13'h0000, 8'ha5, 3'h7, 1'b1);
        push_op(KIND_CHAR_WRITE, 13'h0608, 8'h0f, 3'h0, 1'b0);
        push_op(KIND_CHAR_WRITE, 13'h0e08, 8'h33, 3'h0, 1'b0);
        queue_render(13'h0000, 1'b0);
        queue_render(13'h0000, 1'b1);
        // last group, code zero: empty char pixels, bitmap all set
        push_op(KIND_CHAR_WRITE, 13'h03ff, 8'h00, 3'h7, 1'b1);
        push_op(KIND_BM_WRITE, 13'h1fff, 8'hff, 3'h0, 1'b0);
        push_op(KIND_CHAR_WRITE, 13'h0807, 8'h00, 3'h0, 1'b0);
        queue_render(13'h1fff, 1'b1);
        // plain code with plane two only
        push_op(KIND_CHAR_WRITE, 13'h03ff, 8'h7e, 3'h0, 1'b0);
        push_op(KIND_CHAR_WRITE, 13'h0bf7, 8'h5a, 3'h0, 1'b0);
        queue_render(13'h1fff, 1'b0);
        // code with only the top bit set takes the upper plane pair
        push_op(KIND_CHAR_WRITE, 13'h0000, 8'h80, 3'h0, 1'b0);
        queue_render(13'h0000, 1'b0);
        // unused kind, all ones
        push_op(KIND_UNUSED, 13'h1fff, 8'hff, 3'h7, 1'b1);
        push_op(KIND_CHAR_WRITE, 13'h1fff, 8'hff, 3'h7, 1'b1);
        queue_render(13'h1f00, 1'b1);
        queue_render(13'h00ff, 1'b0);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every due pixel is out, then let the block settle
    task automatic wait_idle;
        while (ops_pending.size() != 0 || in_valid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Phases of layout settings, extremes included
    initial
    begin
        logic alt_tab [0:PHASES-1];
        logic inv_tab [0:PHASES-1];
        int   ph, k;
        alt_tab = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        inv_tab = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (ph = 0; ph < PHASES; ph++)
        begin
            cfg_write(CFG_ALT_LAYOUT, alt_tab[ph]);
            cfg_write(CFG_CONTROL_INVERT, inv_tab[ph]);
            gen_alt = alt_tab[ph];
            for (k = 0; k < 8; k++)
                hot_offs[k] = 13'($urandom_range(0, 8191));
            if (ph == 0)
                directed_ops();
            random_ops(OPS_PER_PHASE);
            wait_idle();
        end
        if (mismatch_cnt == 0)
            $display("** bitmap_char_layer_compositor_core: PASSED **");
        else
            $display("** bitmap_char_layer_compositor_core: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
src/bclc_pkg.sv
src/bclc_ram.sv
src/bitmap_char_layer_compositor_core.sv
src/bclc_checker.sv
tb/bitmap_char_layer_compositor_core_tb.sv
